// ===== rtl/alt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package alt_pkg;

    localparam int ALT_DEPTH      = 64;
    localparam int ALT_DATA_WIDTH = 32;

    // field widths of the beat ports
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 6;
    localparam int VALUE_W = 32;
    localparam int OUT_W   = 7;

    // operation carried by the mode field of an input beat
    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_CHANGE = 2'd1,
        MODE_FIND   = 2'd2,
        MODE_REMOVE = 2'd3
    } mode_t;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic wr;     // write wdata into the cell at target
        logic shift;  // cells in [lo, hi) take their right neighbour's entry
        logic start;  // load the search token into cell 0
        logic run;    // search token moves one cell to the right
    } alt_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/alt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module alt_cell #(
    parameter int POS        = 0,
    parameter int DATA_WIDTH = alt_pkg::ALT_DATA_WIDTH,
    parameter int CNT_W      = 7
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire alt_pkg::alt_cmd_t     cmd,
    input  wire logic [CNT_W-1:0]      target,
    input  wire logic [CNT_W-1:0]      lo,
    input  wire logic [CNT_W-1:0]      hi,
    input  wire logic [DATA_WIDTH-1:0] wdata,
    input  wire logic [DATA_WIDTH-1:0] query,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    input  wire logic                  token_in,
    output logic [DATA_WIDTH-1:0]      data,
    output logic                       token_out,
    output logic                       hit
);
    import alt_pkg::*;

    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(POS);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  token_reg;
    logic                  token_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.wr && (target == MY_POS))
        begin
            data_next = wdata;
        end
        else if (cmd.shift && (MY_POS >= lo) && (MY_POS < hi))
        begin
            data_next = right_data;
        end
    end

    always_comb
    begin
        if (POS == 0)
        begin
            token_next = cmd.start;
        end
        else
        begin
            token_next = cmd.run & token_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= 1'b0;
        end
        else
        begin
            token_reg <= token_next;
        end
    end

    assign data      = data_reg;
    assign token_out = token_reg;
    assign hit       = token_reg & (data_reg == query);

endmodule

`default_nettype wire

// ===== rtl/array_list_table_core.sv =====
// Compacted list of up to DEPTH values held in a row of cells, one entry per cell.
// Each input beat carries mode (0 append, 1 change at index, 2 find value,
// 3 remove at index), index and value; each produces exactly one result beat
// with found_index, the count after the operation and an error flag. For
// append, change and remove the addressed cell is written, or every cell from
// index below the last entry takes its right neighbour's entry, all in the same edge.
// A find walks a token down the row, one cell per cycle, and reports the
// first matching position, or found_index equal to the count when the value is
// absent; a find on an empty list answers at once. Only one beat is in flight;
// a new beat is taken only when no find runs and the last result is taken.
`timescale 1ns / 1ps
`default_nettype none

module array_list_table_core #(
    parameter int DEPTH      = alt_pkg::ALT_DEPTH,
    parameter int DATA_WIDTH = alt_pkg::ALT_DATA_WIDTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [alt_pkg::MODE_W-1:0]  mode,
    input  wire logic [alt_pkg::INDEX_W-1:0] index,
    input  wire logic [alt_pkg::VALUE_W-1:0] value,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [alt_pkg::OUT_W-1:0]        found_index,
    output logic [alt_pkg::OUT_W-1:0]        count,
    output logic                             error
);
    import alt_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int VEXT_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_FIND = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic [DATA_WIDTH-1:0] query_reg, query_next;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      found_reg;
    logic [OUT_W-1:0]      count_out_reg;
    logic                  error_reg;

    logic                  accept;
    logic [VEXT_W-1:0]     value_ext;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  full;
    logic                  in_range;
    logic [CNT_W-1:0]      idx;
    logic [CNT_W-1:0]      scan_inc;
    logic                  scan_last;
    logic                  any_hit;

    alt_cmd_t              cmd;
    logic [CNT_W-1:0]      target;
    logic [CNT_W-1:0]      lo;
    logic [CNT_W-1:0]      hi;

    logic                  res_valid;
    logic [CNT_W-1:0]      res_found;
    logic [CNT_W-1:0]      res_count;
    logic                  res_error;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]      token_vec;
    logic [DEPTH-1:0]      hit_vec;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign value_ext = VEXT_W'(value);
    assign wdata     = value_ext[DATA_WIDTH-1:0];
    assign full      = (count_reg == FULL_COUNT);
    assign in_range  = (CMP_W'(index) < CMP_W'(count_reg));
    assign idx       = CNT_W'(index);
    assign scan_inc  = scan_reg + CNT_W'(1);
    assign scan_last = (scan_inc == count_reg);
    assign any_hit   = |hit_vec;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        query_next = query_reg;
        cmd        = '0;
        target     = count_reg;
        lo         = idx;
        hi         = count_reg - CNT_W'(1);
        res_valid  = 1'b0;
        res_found  = '0;
        res_count  = count_reg;
        res_error  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        MODE_APPEND:
                        begin
                            res_valid = 1'b1;
                            res_error = full;
                            cmd.wr    = !full;
                            target    = count_reg;
                            if (!full)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                            res_count = count_next;
                        end
                        MODE_CHANGE:
                        begin
                            res_valid = 1'b1;
                            res_error = !in_range;
                            cmd.wr    = in_range;
                            target    = idx;
                        end
                        MODE_FIND:
                        begin
                            // empty list answers at once with found_index equal to the count
                            if (count_reg == '0)
                            begin
                                res_valid = 1'b1;
                            end
                            else
                            begin
                                cmd.start  = 1'b1;
                                query_next = wdata;
                                scan_next  = '0;
                                state_next = ST_FIND;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            res_valid = 1'b1;
                            res_error = !in_range;
                            cmd.shift = in_range;
                            if (in_range)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            res_count = count_next;
                        end
                        default:
                        begin
                            res_valid = 1'b0;
                        end
                    endcase
                end
            end
            ST_FIND:
            begin
                // token sits in cell scan_reg this cycle
                if (any_hit || scan_last)
                begin
                    res_valid  = 1'b1;
                    res_found  = any_hit ? scan_reg : count_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.run   = 1'b1;
                    scan_next = scan_inc;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    generate
        for (genvar g = 0; g < DEPTH; g++)
        begin : g_cell
            alt_cell #(
                .POS        (g),
                .DATA_WIDTH (DATA_WIDTH),
                .CNT_W      (CNT_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .target     (target),
                .lo         (lo),
                .hi         (hi),
                .wdata      (wdata),
                .query      (query_reg),
                .right_data (cell_data[(g + 1 < DEPTH) ? g + 1 : g]),
                .token_in   (token_vec[(g > 0) ? g - 1 : 0]),
                .data       (cell_data[g]),
                .token_out  (token_vec[g]),
                .hit        (hit_vec[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            if (res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg <= query_next;
        if (res_valid)
        begin
            found_reg     <= OUT_W'(res_found);
            count_out_reg <= OUT_W'(res_count);
            error_reg     <= res_error;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found_index = found_reg;
    assign count       = count_out_reg;
    assign error       = error_reg;

    // list never grows past its depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_COUNT)
        else $error("entry count above depth");

    // at most one search token in the row
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(token_vec))
        else $error("more than one search token");

    // while searching, the token stays inside the filled part of the row
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIND) |-> (scan_reg < count_reg) && token_vec != '0)
        else $error("search token lost or beyond count");

    // a result never lands on one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!out_valid_reg || out_ready))
        else $error("result beat overwritten");

    // count only moves on an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("count changed without a beat");

endmodule

`default_nettype wire
